FILE: sv/lzw_pkg.sv
// Package of the GIF LZW decoder: item and result types, code constants
// and the dictionary restart helper. Used by lzw_front, lzw_back and the top level.
`default_nettype none
package lzw_pkg;

  localparam int CODE_W       = 12;
  localparam int SLOT_W       = 13;
  localparam int STACK_DEPTH  = 4096;
  localparam int STACK_AW     = 12;
  localparam int FILL_W       = 13;
  localparam int DEF_TABLE_DEPTH   = 4096;
  localparam int DEF_MAX_CODE_BITS = 12;

  localparam logic [3:0]  MCS_RESET = 4'd8;
  localparam logic [15:0] LW_RESET  = 16'd640;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_PULL = 1'b1;

  localparam logic CFG_MIN_CODE_SIZE = 1'b0;
  localparam logic CFG_LINE_WIDTH    = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] bad_tally;
    logic        byte_taken;
    logic        end_of_image;
    logic        end_of_row;
    logic        pixel_valid;
    logic [7:0]  pixel;
  } result_t;

  typedef struct packed {
    logic [3:0]        code_width;
    logic [SLOT_W-1:0] next_slot;
    logic [SLOT_W-1:0] slot_limit;
    logic [SLOT_W-1:0] clear_code;
  } restart_t;

  // Minimum code size clamped to 2..8, then the values a clear code loads.
  function automatic restart_t restart_vals(input logic [3:0] mcs);
    logic [3:0] eff;
    restart_t   r;
    eff = (mcs < 4'd2) ? 4'd2 : ((mcs > 4'd8) ? 4'd8 : mcs);
    r.code_width = eff + 4'd1;
    r.clear_code = SLOT_W'(1) << eff;
    r.next_slot  = r.clear_code + SLOT_W'(2);
    r.slot_limit = SLOT_W'(1) << r.code_width;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/lzw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/lzw_front.sv
// Front of the LZW decoder: accepts input beats into a two-entry queue.
// Depends on lzw_pkg.
`default_nettype none
module lzw_front
  import lzw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       q_valid,
  input  wire logic  q_pop,
  output item_t      q_item
);

  item_t      slot_r [2];
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ pop;
    wr_ptr_nxt = wr_ptr_r ^ push;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

endmodule
`default_nettype wire

FILE: sv/lzw_back.sv
// Back of the LZW decoder: byte unpacking, code decode, dictionary walk,
// pixel stack and the result register. Depends on lzw_pkg and lzw_ram.
`default_nettype none
module lzw_back
  import lzw_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  wire item_t       q_item,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [15:0] cfg_wdata,
  output logic             res_valid,
  input  wire logic        res_ready,
  output result_t          res
);

  localparam int AW = $clog2(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_POPW  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [3:0]        mcs_r, mcs_nxt;
  logic [15:0]       lw_r, lw_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [23:0]       bitbuf_r, bitbuf_nxt;
  logic [4:0]        bits_r, bits_nxt;
  logic [3:0]        cw_r, cw_nxt;
  logic [SLOT_W-1:0] ns_r, ns_nxt;
  logic [SLOT_W-1:0] limit_r, limit_nxt;
  logic [CODE_W-1:0] prev_r, prev_nxt;
  logic [7:0]        first_r, first_nxt;
  logic [15:0]       rc_r, rc_nxt;
  logic [7:0]        bbl_r, bbl_nxt;
  logic [15:0]       bad_r, bad_nxt;
  logic              fin_r, fin_nxt;
  logic              ac_r, ac_nxt;
  logic [CODE_W-1:0] cur_r, cur_nxt;
  logic [CODE_W-1:0] c_r, c_nxt;
  logic              known_r, known_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r, out_nxt;

  restart_t          rs_now, rs_cfg;
  logic              out_free;
  logic              push_en;
  logic [7:0]        push_val;
  logic              st_we;
  logic [7:0]        st_rdata;
  logic [FILL_W-1:0] fill_dec;
  logic              tbl_we;
  logic [7:0]        suf_rdata;
  logic [CODE_W-1:0] pre_rdata;
  logic [CODE_W-1:0] code_mask, code_in, code_z;
  logic [SLOT_W-1:0] ns_inc;
  logic              walk_go;
  logic [16:0]       rc_inc;

  assign rs_now    = restart_vals(mcs_r);
  assign rs_cfg    = restart_vals(cfg_wdata[3:0]);
  assign out_free  = !out_valid_r || res_ready;
  assign fill_dec  = fill_r - FILL_W'(1);
  assign code_mask = ~({CODE_W{1'b1}} << cw_r);
  assign code_in   = bitbuf_r[CODE_W-1:0] & code_mask;
  assign code_z    = ({1'b0, code_in} >= ns_r) ? '0 : code_in;
  assign ns_inc    = ns_r + SLOT_W'(1);
  assign rc_inc    = {1'b0, rc_r} + 17'd1;
  assign walk_go   = ({1'b0, cur_r} >= rs_now.next_slot) && ({1'b0, cur_r} < ns_r)
                     && ({1'b0, cur_r} < SLOT_W'(TABLE_DEPTH))
                     && (fill_r < FILL_W'(STACK_DEPTH));
  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_comb begin
    state_nxt     = state_r;
    mcs_nxt       = mcs_r;
    lw_nxt        = lw_r;
    fill_nxt      = fill_r;
    bitbuf_nxt    = bitbuf_r;
    bits_nxt      = bits_r;
    cw_nxt        = cw_r;
    ns_nxt        = ns_r;
    limit_nxt     = limit_r;
    prev_nxt      = prev_r;
    first_nxt     = first_r;
    rc_nxt        = rc_r;
    bbl_nxt       = bbl_r;
    bad_nxt       = bad_r;
    fin_nxt       = fin_r;
    ac_nxt        = ac_r;
    cur_nxt       = cur_r;
    c_nxt         = c_r;
    known_nxt     = known_r;
    out_valid_nxt = out_valid_r && !res_ready;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    push_en       = 1'b0;
    push_val      = 8'd0;
    tbl_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_item.mode == MODE_PULL) begin
            state_nxt = S_CHECK;
          end else begin
            out_nxt = '0;
            if (fin_r) begin
              out_nxt.byte_taken = 1'b1;
            end else if (fill_r == '0 && {1'b0, bits_r} < {2'b00, cw_r}) begin
              out_nxt.byte_taken = 1'b1;
              if (bbl_r == 8'd0) begin
                if (q_item.data_byte == 8'd0) begin
                  fin_nxt = 1'b1;
                end else begin
                  bbl_nxt = q_item.data_byte;
                end
              end else begin
                bitbuf_nxt = bitbuf_r | (24'(q_item.data_byte) << bits_r);
                bits_nxt   = bits_r + 5'd8;
                bbl_nxt    = bbl_r - 8'd1;
              end
            end
            out_nxt.end_of_image = fin_nxt && (fill_r == '0);
            out_nxt.bad_tally    = bad_r;
            out_valid_nxt        = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (fill_r == '0 && !fin_r && {1'b0, bits_r} >= {2'b00, cw_r}) begin
          state_nxt = S_DEC;
        end else if (fill_r != '0) begin
          fill_nxt  = fill_dec;
          state_nxt = S_POPW;
        end else begin
          out_nxt              = '0;
          out_nxt.end_of_image = fin_r;
          out_nxt.bad_tally    = bad_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      S_DEC: begin
        bitbuf_nxt = bitbuf_r >> cw_r;
        bits_nxt   = bits_r - {1'b0, cw_r};
        state_nxt  = S_CHECK;
        if ({1'b0, code_in} == rs_now.clear_code) begin
          cw_nxt    = rs_now.code_width;
          ns_nxt    = rs_now.next_slot;
          limit_nxt = rs_now.slot_limit;
          ac_nxt    = 1'b1;
        end else if ({1'b0, code_in} == rs_now.clear_code + SLOT_W'(1)) begin
          fin_nxt = 1'b1;
        end else if (ac_r) begin
          prev_nxt  = code_z;
          first_nxt = code_z[7:0];
          push_en   = 1'b1;
          push_val  = code_z[7:0];
          ac_nxt    = 1'b0;
        end else begin
          c_nxt     = code_in;
          known_nxt = ({1'b0, code_in} < ns_r);
          state_nxt = S_WALK;
          if ({1'b0, code_in} < ns_r) begin
            cur_nxt = code_in;
          end else begin
            if ({1'b0, code_in} > ns_r && bad_r != 16'hFFFF) begin
              bad_nxt = bad_r + 16'd1;
            end
            cur_nxt  = prev_r;
            push_en  = 1'b1;
            push_val = first_r;
          end
        end
      end
      S_WALK: begin
        if (walk_go) begin
          state_nxt = S_WAIT;
        end else begin
          push_en   = 1'b1;
          push_val  = cur_r[7:0];
          first_nxt = cur_r[7:0];
          state_nxt = S_CHECK;
          if (ns_r < limit_r && ns_r < SLOT_W'(TABLE_DEPTH)) begin
            tbl_we   = 1'b1;
            prev_nxt = known_r ? c_r : ns_r[CODE_W-1:0];
            ns_nxt   = ns_inc;
            if (ns_inc >= limit_r && cw_r < 4'(MAX_CODE_BITS)) begin
              limit_nxt = limit_r << 1;
              cw_nxt    = cw_r + 4'd1;
            end
          end else begin
            if (known_r) begin
              prev_nxt = c_r;
            end
            if (ns_r >= limit_r && cw_r < 4'(MAX_CODE_BITS)) begin
              limit_nxt = limit_r << 1;
              cw_nxt    = cw_r + 4'd1;
            end
          end
        end
      end
      S_WAIT: begin
        push_en   = 1'b1;
        push_val  = suf_rdata;
        cur_nxt   = pre_rdata;
        state_nxt = S_WALK;
      end
      S_POPW: begin
        out_nxt             = '0;
        out_nxt.pixel       = st_rdata;
        out_nxt.pixel_valid = 1'b1;
        if (rc_inc >= {1'b0, lw_r}) begin
          out_nxt.end_of_row = 1'b1;
          rc_nxt             = 16'd0;
        end else begin
          rc_nxt = rc_inc[15:0];
        end
        out_nxt.end_of_image = fin_r && (fill_r == '0);
        out_nxt.bad_tally    = bad_r;
        out_valid_nxt        = 1'b1;
        state_nxt            = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    st_we = push_en && (fill_r < FILL_W'(STACK_DEPTH));
    if (st_we) begin
      fill_nxt = fill_r + FILL_W'(1);
    end

    // The user must write the configuration only while the decoder is idle; the block does not enforce this.
    if (cfg_we) begin
      if (cfg_idx == CFG_MIN_CODE_SIZE) begin
        mcs_nxt   = cfg_wdata[3:0];
        cw_nxt    = rs_cfg.code_width;
        ns_nxt    = rs_cfg.next_slot;
        limit_nxt = rs_cfg.slot_limit;
        prev_nxt  = '0;
        first_nxt = 8'd0;
      end else begin
        lw_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mcs_r       <= MCS_RESET;
      lw_r        <= LW_RESET;
      fill_r      <= '0;
      bitbuf_r    <= '0;
      bits_r      <= '0;
      cw_r        <= restart_vals(MCS_RESET).code_width;
      ns_r        <= restart_vals(MCS_RESET).next_slot;
      limit_r     <= restart_vals(MCS_RESET).slot_limit;
      prev_r      <= '0;
      first_r     <= '0;
      rc_r        <= '0;
      bbl_r       <= '0;
      bad_r       <= '0;
      fin_r       <= 1'b0;
      ac_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mcs_r       <= mcs_nxt;
      lw_r        <= lw_nxt;
      fill_r      <= fill_nxt;
      bitbuf_r    <= bitbuf_nxt;
      bits_r      <= bits_nxt;
      cw_r        <= cw_nxt;
      ns_r        <= ns_nxt;
      limit_r     <= limit_nxt;
      prev_r      <= prev_nxt;
      first_r     <= first_nxt;
      rc_r        <= rc_nxt;
      bbl_r       <= bbl_nxt;
      bad_r       <= bad_nxt;
      fin_r       <= fin_nxt;
      ac_r        <= ac_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    c_r     <= c_nxt;
    known_r <= known_nxt;
    out_r   <= out_nxt;
  end

  lzw_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (fill_r[STACK_AW-1:0]),
    .wdata (push_val),
    .raddr (fill_dec[STACK_AW-1:0]),
    .rdata (st_rdata)
  );

  lzw_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_suffix (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (ns_r[AW-1:0]),
    .wdata (cur_r[7:0]),
    .raddr (cur_r[AW-1:0]),
    .rdata (suf_rdata)
  );

  lzw_ram #(.WIDTH(CODE_W), .DEPTH(TABLE_DEPTH)) u_prefix (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (ns_r[AW-1:0]),
    .wdata (prev_r),
    .raddr (cur_r[AW-1:0]),
    .rdata (pre_rdata)
  );

endmodule
`default_nettype wire

FILE: sv/lzw_variable_width_decoder.sv
// GIF LZW image data decoder, top level: input queue plus decode engine.
// Depends on lzw_pkg, lzw_front, lzw_back and lzw_ram.
//
// Usage: every input beat is either a stream byte (in_tuser = 0, byte in
// in_tdata) or a pull for one pixel (in_tuser = 1). Every input beat yields
// exactly one output beat, in order. For a byte the output says whether it
// was absorbed; a refused byte must be offered again. For a pull the output
// carries a pixel if one could be decoded, with out_tlast on the last pixel
// of each row. The configuration channel sets the minimum code size
// (index 0) and the row width (index 1); write it only while idle.
// A byte passes the input queue and then the output register. A pull
// that finds pixels stacked passes the queue, the stack check, the
// registered stack read and the output register. A pull that must decode
// adds a decode and a recheck per code, a walk and a wait per dictionary
// entry, because each step waits on the registered read of the prefix and
// suffix RAMs, and a last walk step to close the walk. Bytes can be taken
// one per cycle while the receiver is ready; the engine takes no new beat
// until a pull has produced its output beat. A two-entry input queue keeps
// accepting beats while the output register waits on the receiver; when
// the receiver stalls, the engine holds its next result until the output
// register drains. Reset restores the default code size of 8 and row width
// of 640; the dictionary and stack RAMs need no clearing pass.
`default_nettype none
module lzw_variable_width_decoder
  import lzw_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] pixel, [8] end_of_image,
                                       // [9] byte_taken, [25:10] bad_tally
  output logic             out_tuser,  // [0] pixel_valid
  output logic             out_tlast,  // end_of_row
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_pop;
  result_t res;

  assign in_item.mode      = in_tuser;
  assign in_item.data_byte = in_tdata;
  assign cfg_ready         = 1'b1;

  lzw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  lzw_back #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {6'd0, res.bad_tally, res.byte_taken, res.end_of_image, res.pixel};
  assign out_tuser = res.pixel_valid;
  assign out_tlast = res.end_of_row;

endmodule
`default_nettype wire
